@@ sv/bptc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared widths, constants and register indexes for the barometric pressure
// and temperature compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DT_W    = RAW_W + 1;
  localparam int TEMP_W  = 20;
  localparam int TOUT_W  = 19;
  localparam int PRES_W  = 32;
  localparam int ACC_W   = 40;

  // accept edge to result strobe, in cycles
  localparam int PIPE_DEPTH = 7;

  localparam logic [RAW_W-1:0] RAW_PRESSURE_FLOOR = RAW_W'(9085466 * 2 / 3);

  localparam logic signed [TEMP_W-1:0] TEMP_KNEE_HIGH = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_KNEE_LOW  = -20'sd1500;

  localparam int SLOPE_SHIFT = 23;
  localparam int OFF_SHIFT   = 7;
  localparam int SENS_SHIFT  = 8;
  localparam int DTSQ_SHIFT  = 31;
  localparam int PROD_SHIFT  = 21;
  localparam int PRES_SHIFT  = 15;

  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY_TEMP_COEFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_SLOPE      = 3'd5;

endpackage

@@ sv/baro_pressure_temp_compensation.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Second-order compensation of raw pressure and temperature conversions with
// six calibration words; gives pressure in Pa and temperature in 0.01 C.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | start, busy          | raw_pressure, raw_temperature
//  result   | done (one cycle)     | pressure_pa, temperature_centi, valid_res
//  config   | cfg_we               | cfg_idx, cfg_data
//
//  One beat is taken every cycle while not busy; the result strobe follows
//  the accept edge through the stages of the multiplier chain (difference,
//  products, terms, squares, corrections, split pressure product, output).
//  busy is high only during reset. rst clears the stage valid bits and the
//  calibration words. Results cannot be held off, so nothing stalls.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [bptc_pkg::RAW_W-1:0]           raw_pressure,
  input  logic [bptc_pkg::RAW_W-1:0]           raw_temperature,
  output logic                                 done,
  output logic signed [bptc_pkg::PRES_W-1:0]   pressure_pa,
  output logic signed [bptc_pkg::TOUT_W-1:0]   temperature_centi,
  output logic                                 valid_res,
  input  logic                                 cfg_we,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [bptc_pkg::COEF_W-1:0]          cfg_data
);

  localparam int ACC_W  = bptc_pkg::ACC_W;
  localparam int TEMP_W = bptc_pkg::TEMP_W;

  logic [15:0] pressure_sensitivity;
  logic [15:0] pressure_offset;
  logic [15:0] sensitivity_temp_coeff;
  logic [15:0] offset_temp_coeff;
  logic [15:0] reference_temperature;
  logic [15:0] temperature_slope;

  // calibration words
  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_sensitivity   <= '0;
      pressure_offset        <= '0;
      sensitivity_temp_coeff <= '0;
      offset_temp_coeff      <= '0;
      reference_temperature  <= '0;
      temperature_slope      <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        bptc_pkg::REG_PRESSURE_SENSITIVITY:   pressure_sensitivity   <= cfg_data;
        bptc_pkg::REG_PRESSURE_OFFSET:        pressure_offset        <= cfg_data;
        bptc_pkg::REG_SENSITIVITY_TEMP_COEFF: sensitivity_temp_coeff <= cfg_data;
        bptc_pkg::REG_OFFSET_TEMP_COEFF:      offset_temp_coeff      <= cfg_data;
        bptc_pkg::REG_REFERENCE_TEMPERATURE:  reference_temperature  <= cfg_data;
        bptc_pkg::REG_TEMPERATURE_SLOPE:      temperature_slope      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // ---------------- stage 1: temperature difference ----------------
  logic                   accept;
  logic                   bad_in;
  logic signed [24:0]     dt_in;

  assign accept = start && !busy;
  assign bad_in = (raw_pressure <= bptc_pkg::RAW_PRESSURE_FLOOR) || (raw_temperature == '0);
  assign dt_in  = $signed({1'b0, raw_temperature})
                - $signed({1'b0, reference_temperature, 8'h00});

  logic                   s1_valid, s1_bad;
  logic [23:0]            s1_d1;
  logic signed [24:0]     s1_dt;

  // ---------------- stage 2: first products ----------------
  logic signed [41:0]     p_slope, p_off, p_sens;
  logic signed [49:0]     p_dd;

  assign p_slope = s1_dt * $signed({1'b0, temperature_slope});
  assign p_off   = s1_dt * $signed({1'b0, offset_temp_coeff});
  assign p_sens  = s1_dt * $signed({1'b0, sensitivity_temp_coeff});
  assign p_dd    = s1_dt * s1_dt;

  logic                   s2_valid, s2_bad;
  logic [23:0]            s2_d1;
  logic signed [41:0]     s2_p_slope, s2_p_off, s2_p_sens;
  logic signed [49:0]     s2_p_dd;

  // ---------------- stage 3: first-order terms ----------------
  logic signed [18:0]       t_shift;
  logic signed [TEMP_W-1:0] temp1, d_hi, e_lo;
  logic signed [ACC_W-1:0]  off1, sens1;

  assign t_shift = s2_p_slope[41:bptc_pkg::SLOPE_SHIFT];
  assign temp1   = $signed({t_shift[18], t_shift}) + bptc_pkg::TEMP_KNEE_HIGH;
  assign d_hi    = temp1 - bptc_pkg::TEMP_KNEE_HIGH;
  assign e_lo    = temp1 - bptc_pkg::TEMP_KNEE_LOW;
  assign off1    = $signed({8'h00, pressure_offset, 16'h0000})
                 + $signed({{5{s2_p_off[41]}}, s2_p_off[41:bptc_pkg::OFF_SHIFT]});
  assign sens1   = $signed({9'h000, pressure_sensitivity, 15'h0000})
                 + $signed({{6{s2_p_sens[41]}}, s2_p_sens[41:bptc_pkg::SENS_SHIFT]});

  logic                     s3_valid, s3_bad, s3_lt_high, s3_lt_low;
  logic [23:0]              s3_d1;
  logic signed [TEMP_W-1:0] s3_temp, s3_d, s3_e;
  logic signed [ACC_W-1:0]  s3_off, s3_sens;
  logic [16:0]              s3_dtsq;

  // ---------------- stage 4: squares of the knee distances ----------------
  logic signed [2*TEMP_W-1:0] sq_d, sq_e;

  assign sq_d = s3_d * s3_d;
  assign sq_e = s3_e * s3_e;

  logic                     s4_valid, s4_bad, s4_lt_high, s4_lt_low;
  logic [23:0]              s4_d1;
  logic signed [TEMP_W-1:0] s4_temp;
  logic signed [ACC_W-1:0]  s4_off, s4_sens, s4_sq_d, s4_sq_e;
  logic [16:0]              s4_dtsq;

  // ---------------- stage 5: second-order corrections ----------------
  logic signed [ACC_W-1:0]  five_dd, seven_ee, eleven_ee;
  logic signed [ACC_W-1:0]  corr_off, corr_sens;
  logic signed [ACC_W-1:0]  off2, sens2;
  logic signed [TEMP_W-1:0] temp2;

  assign five_dd   = (s4_sq_d <<< 2) + s4_sq_d;
  assign seven_ee  = (s4_sq_e <<< 3) - s4_sq_e;
  assign eleven_ee = (s4_sq_e <<< 3) + (s4_sq_e <<< 1) + s4_sq_e;

  // squares are never negative, so the shifts below are exact floors
  assign corr_off  = (s4_lt_high ? (five_dd >>> 1) : '0)
                   + (s4_lt_low  ? seven_ee : '0);
  assign corr_sens = (s4_lt_high ? (five_dd >>> 2) : '0)
                   + (s4_lt_low  ? (eleven_ee >>> 1) : '0);
  assign off2      = s4_off - corr_off;
  assign sens2     = s4_sens - corr_sens;
  assign temp2     = s4_temp - (s4_lt_high ? $signed({3'b000, s4_dtsq}) : '0);

  logic                     s5_valid, s5_bad;
  logic [23:0]              s5_d1;
  logic signed [TEMP_W-1:0] s5_temp;
  logic signed [ACC_W-1:0]  s5_off, s5_sens;

  // ---------------- stage 6: pressure product in two halves ----------------
  // d1*sens >> 21 = d1*sens_hi + (d1*sens_lo >> 21), sens_lo unsigned
  logic signed [18:0] sens_hi;
  logic [20:0]        sens_lo;
  logic signed [43:0] p_hi;
  logic [44:0]        p_lo;

  assign sens_hi = s5_sens[ACC_W-1:bptc_pkg::PROD_SHIFT];
  assign sens_lo = s5_sens[bptc_pkg::PROD_SHIFT-1:0];
  assign p_hi    = $signed({1'b0, s5_d1}) * sens_hi;
  assign p_lo    = s5_d1 * sens_lo;

  logic                     s6_valid, s6_bad;
  logic signed [TEMP_W-1:0] s6_temp;
  logic signed [ACC_W-1:0]  s6_off;
  logic signed [43:0]       s6_p_hi;
  logic [44:0]              s6_p_lo;

  // ---------------- stage 7: pressure and output ----------------
  logic signed [47:0] press_sum;

  assign press_sum = $signed({{4{s6_p_hi[43]}}, s6_p_hi})
                   + $signed({24'h000000, s6_p_lo[44:bptc_pkg::PROD_SHIFT]})
                   - $signed({{8{s6_off[ACC_W-1]}}, s6_off});

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      done     <= s6_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    s1_bad <= bad_in;
    s1_d1  <= raw_pressure;
    s1_dt  <= dt_in;

    s2_bad     <= s1_bad;
    s2_d1      <= s1_d1;
    s2_p_slope <= p_slope;
    s2_p_off   <= p_off;
    s2_p_sens  <= p_sens;
    s2_p_dd    <= p_dd;

    s3_bad     <= s2_bad;
    s3_d1      <= s2_d1;
    s3_temp    <= temp1;
    s3_d       <= d_hi;
    s3_e       <= e_lo;
    s3_lt_high <= temp1 < bptc_pkg::TEMP_KNEE_HIGH;
    s3_lt_low  <= temp1 < bptc_pkg::TEMP_KNEE_LOW;
    s3_off     <= off1;
    s3_sens    <= sens1;
    s3_dtsq    <= s2_p_dd[47:bptc_pkg::DTSQ_SHIFT];

    s4_bad     <= s3_bad;
    s4_d1      <= s3_d1;
    s4_temp    <= s3_temp;
    s4_lt_high <= s3_lt_high;
    s4_lt_low  <= s3_lt_low;
    s4_off     <= s3_off;
    s4_sens    <= s3_sens;
    s4_dtsq    <= s3_dtsq;
    s4_sq_d    <= sq_d;
    s4_sq_e    <= sq_e;

    s5_bad  <= s4_bad;
    s5_d1   <= s4_d1;
    s5_temp <= temp2;
    s5_off  <= off2;
    s5_sens <= sens2;

    s6_bad  <= s5_bad;
    s6_temp <= s5_temp;
    s6_off  <= s5_off;
    s6_p_hi <= p_hi;
    s6_p_lo <= p_lo;

    // implausible raw values give zero readings
    pressure_pa       <= s6_bad ? '0 : press_sum[bptc_pkg::PRES_SHIFT+31:bptc_pkg::PRES_SHIFT];
    temperature_centi <= s6_bad ? '0 : s6_temp[bptc_pkg::TOUT_W-1:0];
    valid_res         <= !s6_bad;
  end

endmodule

@@ sv/bptc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_checker
// Port-level checks on beat timing and the plausibility gate of the
// compensation pipeline.
// ----------------------------------------------------------------------------
module bptc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic [bptc_pkg::RAW_W-1:0]         raw_pressure,
  input logic [bptc_pkg::RAW_W-1:0]         raw_temperature,
  input logic                               done,
  input logic signed [bptc_pkg::PRES_W-1:0] pressure_pa,
  input logic signed [bptc_pkg::TOUT_W-1:0] temperature_centi,
  input logic                               valid_res
);

  logic in_beat;
  logic in_good;
  logic [bptc_pkg::PIPE_DEPTH-1:0] beat_hist;
  logic [bptc_pkg::PIPE_DEPTH-1:0] good_hist;

  assign in_beat = start && !busy;
  assign in_good = in_beat && (raw_pressure > bptc_pkg::RAW_PRESSURE_FLOOR)
                   && (raw_temperature != '0);

  // accepted beats and their plausibility, flushed by reset like the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_hist <= '0;
      good_hist <= '0;
    end else begin
      beat_hist <= {beat_hist[bptc_pkg::PIPE_DEPTH-2:0], in_beat};
      good_hist <= {good_hist[bptc_pkg::PIPE_DEPTH-2:0], in_good};
    end
  end

  // every accepted beat gives exactly one result, a fixed time later
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == beat_hist[bptc_pkg::PIPE_DEPTH-1])
    else $error("result strobe does not match accepted beat");

  a_valid_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (valid_res == good_hist[bptc_pkg::PIPE_DEPTH-1]))
    else $error("valid_res does not match plausibility of the raw values");

  a_zero_when_bad: assert property (@(posedge clk) disable iff (rst)
    (done && !valid_res) |-> (pressure_pa == '0 && temperature_centi == '0))
    else $error("rejected beat carries non-zero readings");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (
  .clk               (clk),
  .rst               (rst),
  .start             (start),
  .busy              (busy),
  .raw_pressure      (raw_pressure),
  .raw_temperature   (raw_temperature),
  .done              (done),
  .pressure_pa       (pressure_pa),
  .temperature_centi (temperature_centi),
  .valid_res         (valid_res)
);
